>>> rtl/rbs_pkg.sv
// Shared constants and types for the record bubble sorter.
package rbs_pkg;

   localparam int DEPTH           = 64;
   localparam int PAYLOAD_BITS    = 32;
   localparam int KEY_BITS        = 8;
   localparam int IO_PAYLOAD_BITS = 32;

   // Payload bits actually kept in the store.
   localparam int PL_KEEP    = (PAYLOAD_BITS < IO_PAYLOAD_BITS) ? PAYLOAD_BITS
                                                                 : IO_PAYLOAD_BITS;
   localparam int ENTRY_BITS = KEY_BITS + PL_KEEP;
   localparam int IDX_BITS   = $clog2(DEPTH);
   localparam int CNT_BITS   = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SORT_START,
      ST_PASS,
      ST_PASS_END,
      ST_EMIT_READ,
      ST_EMIT_WAIT
   } state_type;

endpackage

>>> rtl/record_bubble_sort_by_first_byte.sv
// Record sorter top level: loads a set of records, bubble-sorts them by key, streams them out.
//
// Usage: records arrive on the req_ channel, one per transfer, each with a signed
// 8-bit key and a payload. The transfer with req_last_record high closes the set.
// Up to DEPTH records are held; further records of the set are dropped and the
// whole run then reports rsp_overflow. After the closing transfer the block sorts
// the set ascending by key (equal keys keep their load order) and sends it on the
// rsp_ channel, rsp_end_of_run marking the final record of the run.
// Loading accepts one record per cycle while req_stall is low. A sort pass reads the
// records of its range through the single RAM read port, since every compare needs one
// read; the range shrinks by one per pass and sorting stops after a pass without a swap.
// Emission reads each record from the RAM, then loads it into the output register.
// While sorting or emitting, req_stall is high. A stall on rsp_ holds the output
// register and pauses emission; once the last record of a run sits in the output
// register the block takes the next set's records even if that record still waits.
// Reset (synchronous, active high) empties the set and the output register; the
// record store itself is not cleared, as only entries written in the current set
// are ever read.
module record_bubble_sort_by_first_byte
   import rbs_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [KEY_BITS-1:0]        req_key,
   input  logic        [IO_PAYLOAD_BITS-1:0] req_payload,
   input  logic                              req_last_record,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [KEY_BITS-1:0]        rsp_sorted_key,
   output logic        [IO_PAYLOAD_BITS-1:0] rsp_sorted_payload,
   output logic                              rsp_end_of_run,
   output logic                              rsp_overflow
);

   state_type                  state_ff, state_in;
   logic [CNT_BITS-1:0]        count_ff, count_in;
   logic                       dropped_ff, dropped_in;
   logic [CNT_BITS-1:0]        limit_ff, limit_in;
   logic [IDX_BITS-1:0]        proc_ff, proc_in;
   logic                       swapped_ff, swapped_in;
   logic [ENTRY_BITS-1:0]      carry_ff, carry_in;
   logic [IDX_BITS-1:0]        emit_ff, emit_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [KEY_BITS-1:0]        rsp_key_ff, rsp_key_in;
   logic [IO_PAYLOAD_BITS-1:0] rsp_payload_ff, rsp_payload_in;
   logic                       rsp_end_ff, rsp_end_in;
   logic                       rsp_overflow_ff, rsp_overflow_in;

   logic                       ram_we;
   logic [IDX_BITS-1:0]        ram_waddr;
   logic [ENTRY_BITS-1:0]      ram_wdata;
   logic                       ram_re;
   logic [IDX_BITS-1:0]        ram_raddr;
   logic [ENTRY_BITS-1:0]      ram_rdata;

   logic [KEY_BITS-1:0]        rd_key;
   logic [KEY_BITS-1:0]        carry_key;
   logic [CNT_BITS-1:0]        proc_next;
   logic [CNT_BITS-1:0]        limit_m1;
   logic                       emit_last;

   // Keys and payloads of the set live side by side in one memory word.
   rbs_ram #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign rd_key    = ram_rdata[ENTRY_BITS-1 -: KEY_BITS];
   assign carry_key = carry_ff[ENTRY_BITS-1 -: KEY_BITS];
   assign proc_next = CNT_BITS'(proc_ff) + CNT_BITS'(1);
   assign limit_m1  = limit_ff - CNT_BITS'(1);
   assign emit_last = (CNT_BITS'(emit_ff) + CNT_BITS'(1)) == count_ff;

   assign req_stall = (state_ff != ST_IDLE);

   // A sort pass streams the range through the read port. The record that is
   // bubbling toward the top is held in carry_ff; each newly read record is
   // compared with it, and whichever is smaller (the carried one only when
   // strictly greater moves on) is written one place lower. Writes always
   // trail reads, so no entry is read and written in the same cycle.
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      dropped_in      = dropped_ff;
      limit_in        = limit_ff;
      proc_in         = proc_ff;
      swapped_in      = swapped_ff;
      carry_in        = carry_ff;
      emit_in         = emit_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_key_in      = rsp_key_ff;
      rsp_payload_in  = rsp_payload_ff;
      rsp_end_in      = rsp_end_ff;
      rsp_overflow_in = rsp_overflow_ff;
      ram_we          = 1'b0;
      ram_waddr       = '0;
      ram_wdata       = '0;
      ram_re          = 1'b0;
      ram_raddr       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (count_ff < CNT_BITS'(DEPTH)) begin
                  ram_we    = 1'b1;
                  ram_waddr = count_ff[IDX_BITS-1:0];
                  ram_wdata = {req_key, req_payload[PL_KEEP-1:0]};
                  count_in  = count_ff + CNT_BITS'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last_record) begin
                  limit_in   = count_in;
                  swapped_in = 1'b1;
                  state_in   = ST_SORT_START;
               end
            end
         end

         ST_SORT_START: begin
            if (swapped_ff && (limit_ff > CNT_BITS'(1))) begin
               ram_re     = 1'b1;
               ram_raddr  = '0;
               proc_in    = '0;
               swapped_in = 1'b0;
               state_in   = ST_PASS;
            end else begin
               emit_in  = '0;
               state_in = ST_EMIT_READ;
            end
         end

         ST_PASS: begin
            if (proc_ff == '0) begin
               carry_in = ram_rdata;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = proc_ff - IDX_BITS'(1);
               if ($signed(carry_key) > $signed(rd_key)) begin
                  ram_wdata  = ram_rdata;
                  swapped_in = 1'b1;
               end else begin
                  ram_wdata = carry_ff;
                  carry_in  = ram_rdata;
               end
            end
            if (proc_next < limit_ff) begin
               ram_re    = 1'b1;
               ram_raddr = proc_next[IDX_BITS-1:0];
               proc_in   = proc_next[IDX_BITS-1:0];
            end else begin
               state_in = ST_PASS_END;
            end
         end

         ST_PASS_END: begin
            // The largest record of the range settles at its top.
            ram_we    = 1'b1;
            ram_waddr = limit_m1[IDX_BITS-1:0];
            ram_wdata = carry_ff;
            limit_in  = limit_m1;
            state_in  = ST_SORT_START;
         end

         ST_EMIT_READ: begin
            // Read only when the output register is free by the next cycle.
            if (!rsp_valid_ff || !rsp_stall) begin
               ram_re    = 1'b1;
               ram_raddr = emit_ff;
               state_in  = ST_EMIT_WAIT;
            end
         end

         ST_EMIT_WAIT: begin
            rsp_valid_in    = 1'b1;
            rsp_key_in      = rd_key;
            rsp_payload_in  = IO_PAYLOAD_BITS'(ram_rdata[PL_KEEP-1:0]);
            rsp_end_in      = emit_last;
            rsp_overflow_in = dropped_ff;
            if (emit_last) begin
               count_in   = '0;
               dropped_in = 1'b0;
               state_in   = ST_IDLE;
            end else begin
               emit_in  = emit_ff + IDX_BITS'(1);
               state_in = ST_EMIT_READ;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      limit_ff        <= limit_in;
      proc_ff         <= proc_in;
      swapped_ff      <= swapped_in;
      carry_ff        <= carry_in;
      emit_ff         <= emit_in;
      rsp_key_ff      <= rsp_key_in;
      rsp_payload_ff  <= rsp_payload_in;
      rsp_end_ff      <= rsp_end_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sorted_key     = $signed(rsp_key_ff);
   assign rsp_sorted_payload = rsp_payload_ff;
   assign rsp_end_of_run     = rsp_end_ff;
   assign rsp_overflow       = rsp_overflow_ff;

`ifndef SYNTHESIS
   // The record count never exceeds the store depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("record count beyond store depth");

   // A pass never works beyond the current range.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PASS) |-> (CNT_BITS'(proc_ff) < limit_ff))
      else $error("sort pass index outside range");

   // The output register is only loaded when it is free.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_WAIT) |-> !(rsp_valid_ff && rsp_stall))
      else $error("output register overwritten while stalled");

   // Sending the last record of a run returns the block to loading with an empty set.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_WAIT && emit_last) |=>
         (state_ff == ST_IDLE && count_ff == '0 && !dropped_ff && rsp_end_of_run))
      else $error("run end did not clear the set");

   // Sort writes stay within the range being sorted.
   assert property (@(posedge clock) disable iff (reset)
      (ram_we && (state_ff == ST_PASS || state_ff == ST_PASS_END)) |->
         (CNT_BITS'(ram_waddr) < limit_ff))
      else $error("sort write outside range");
`endif

endmodule

>>> rtl/rbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/record_bubble_sort_by_first_byte_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the record bubble sorter: directed, capacity and random sets.
module record_bubble_sort_by_first_byte_tb;
   import rbs_pkg::*;

   // A sort of DEPTH reverse-ordered records runs with no transfer on either side;
   // the limit leaves a wide margin over the length of that sort.
   localparam int WATCHDOG_LIMIT = 20000;
   // After the last expected record, keep watching long enough to catch stray results.
   localparam int DRAIN_CYCLES   = 400;
   // Random sets are added until about this many records have been sent in all.
   localparam int RANDOM_RECORDS = 310;
   // Payload bits the store keeps; everything above them comes back as zero.
   localparam logic [IO_PAYLOAD_BITS-1:0] KEEP_MASK =
      {IO_PAYLOAD_BITS{1'b1}} >> (IO_PAYLOAD_BITS - PL_KEEP);

   // How a side of the block paces its traffic.
   typedef enum logic {
      PACE_STEADY,
      PACE_BURSTY
   } pace_type;

   // Key ordering used to build a random set.
   typedef enum logic [1:0] {
      KEYS_SCATTERED,
      KEYS_CLUSTERED,
      KEYS_RISING
   } key_style_type;

   typedef struct {
      logic signed [KEY_BITS-1:0]        key;
      logic        [IO_PAYLOAD_BITS-1:0] payload;
      logic                              end_of_run;
      logic                              overflow;
   } sorted_record_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic signed [KEY_BITS-1:0]        req_key = '0;
   logic        [IO_PAYLOAD_BITS-1:0] req_payload = '0;
   logic                              req_last_record = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic signed [KEY_BITS-1:0]        rsp_sorted_key;
   logic        [IO_PAYLOAD_BITS-1:0] rsp_sorted_payload;
   logic                              rsp_end_of_run;
   logic                              rsp_overflow;

   // Predictor state: the records of the set being loaded, in load order.
   logic signed [KEY_BITS-1:0]        held_key [DEPTH];
   logic        [IO_PAYLOAD_BITS-1:0] held_payload [DEPTH];
   int                                held_count = 0;
   bit                                records_lost = 1'b0;

   // Sorted records the block still owes us, oldest first.
   sorted_record_type sorted_run_q[$];

   pace_type send_pace  = PACE_STEADY;
   pace_type drain_pace = PACE_STEADY;

   int error_count     = 0;
   int records_sent    = 0;
   int sets_closed     = 0;
   int overflow_runs   = 0;
   int records_checked = 0;
   int idle_cycles     = 0;
   int stall_hold      = 0;
   int stall_len;

   record_bubble_sort_by_first_byte DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_key            (req_key),
      .req_payload        (req_payload),
      .req_last_record    (req_last_record),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sorted_key     (rsp_sorted_key),
      .rsp_sorted_payload (rsp_sorted_payload),
      .rsp_end_of_run     (rsp_end_of_run),
      .rsp_overflow       (rsp_overflow)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Idle length for one gap: mostly none or a few cycles, now and then a long one.
   function automatic int pick_gap(input pace_type pace);
      int roll;
      if (pace == PACE_STEADY) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Loads one accepted record into the predicted store. A record that finds the store
   // full is dropped and marks the set as overflowed. The closing record sorts the set
   // exactly as the block should: passes over a shrinking range, swapping only on a
   // strictly greater left key so that equal keys keep their load order, and stopping
   // after the first pass without a swap. The sorted set becomes the expected run.
   function automatic void absorb_record(input logic signed [KEY_BITS-1:0]        key,
                                         input logic        [IO_PAYLOAD_BITS-1:0] payload,
                                         input bit                                closing);
      int                                range_end;
      bit                                swapped;
      logic signed [KEY_BITS-1:0]        swap_key;
      logic        [IO_PAYLOAD_BITS-1:0] swap_payload;
      sorted_record_type                 rec;
      if (held_count < DEPTH) begin
         held_key[held_count]     = key;
         held_payload[held_count] = payload & KEEP_MASK;
         held_count++;
      end else begin
         records_lost = 1'b1;
      end
      if (!closing) begin
         return;
      end
      range_end = held_count;
      swapped   = 1'b1;
      while (swapped && range_end > 1) begin
         swapped = 1'b0;
         for (int i = 1; i < range_end; i++) begin
            if (held_key[i-1] > held_key[i]) begin
               swap_key          = held_key[i-1];
               swap_payload      = held_payload[i-1];
               held_key[i-1]     = held_key[i];
               held_payload[i-1] = held_payload[i];
               held_key[i]       = swap_key;
               held_payload[i]   = swap_payload;
               swapped           = 1'b1;
            end
         end
         range_end--;
      end
      for (int i = 0; i < held_count; i++) begin
         rec.key        = held_key[i];
         rec.payload    = held_payload[i];
         rec.end_of_run = (i == held_count - 1);
         rec.overflow   = records_lost;
         sorted_run_q.push_back(rec);
      end
      if (records_lost) begin
         overflow_runs++;
      end
      sets_closed++;
      held_count   = 0;
      records_lost = 1'b0;
   endfunction

   // Sends one record and returns at the edge where its transfer happens. Valid stays
   // high across back-to-back records, so it is only lowered when a gap is wanted.
   task automatic send_record(input logic signed [KEY_BITS-1:0]        key,
                              input logic        [IO_PAYLOAD_BITS-1:0] payload,
                              input bit                                closing);
      int gap;
      gap = pick_gap(send_pace);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_key         <= key;
      req_payload     <= payload;
      req_last_record <= closing;
      do @(posedge clock); while (req_stall);
      absorb_record(key, payload, closing);
      records_sent++;
   endtask

   // Receiver back-pressure: alternating stalled and open windows of random length
   // while the drain side is bursty, never stalled while it is steady.
   always @(posedge clock) begin : drive_rsp_stall
      if (reset || drain_pace == PACE_STEADY) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else if (rsp_stall) begin
         rsp_stall  <= 1'b0;
         stall_hold <= $urandom_range(0, 6);
      end else begin
         stall_len  = pick_gap(drain_pace);
         rsp_stall  <= (stall_len > 0);
         stall_hold <= (stall_len > 0) ? stall_len - 1 : 0;
      end
   end

   // Every transfer on the result side is matched against the oldest expected record.
   always @(posedge clock) begin : check_sorted_records
      sorted_record_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sorted_run_q.size() == 0) begin
            $display("%0t: unexpected record: key %0d payload %h end %b overflow %b",
                     $time, rsp_sorted_key, rsp_sorted_payload, rsp_end_of_run,
                     rsp_overflow);
            error_count++;
         end else begin
            want = sorted_run_q.pop_front();
            if (rsp_sorted_key !== want.key) begin
               $display("%0t: sorted_key expected %0d actual %0d",
                        $time, want.key, rsp_sorted_key);
               error_count++;
            end
            if (rsp_sorted_payload !== want.payload) begin
               $display("%0t: sorted_payload expected %h actual %h",
                        $time, want.payload, rsp_sorted_payload);
               error_count++;
            end
            if (rsp_end_of_run !== want.end_of_run) begin
               $display("%0t: end_of_run expected %b actual %b",
                        $time, want.end_of_run, rsp_end_of_run);
               error_count++;
            end
            if (rsp_overflow !== want.overflow) begin
               $display("%0t: overflow expected %b actual %b",
                        $time, want.overflow, rsp_overflow);
               error_count++;
            end
            records_checked++;
         end
      end
   end

   // Ends the run if neither side moves a transfer for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d records still expected",
                  $time, idle_cycles, sorted_run_q.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Short hand-picked sets: a lone closing record, the key and payload extremes,
   // signed ordering around zero, stability of equal keys, an already sorted set that
   // should stop after one pass, and a fully reversed set.
   task automatic test_directed_sets();
      send_pace  = PACE_STEADY;
      drain_pace = PACE_STEADY;
      send_record(8'sd0, 32'h0000_0000, 1'b1);

      send_record(8'h7F, 32'hFFFF_FFFF, 1'b0);
      send_record(8'h80, 32'h0000_0000, 1'b1);

      // Equal keys must come out in load order; the payload tags show that order.
      send_record(8'sd5, 32'h0000_0001, 1'b0);
      send_record(-8'sd3, 32'h0000_0002, 1'b0);
      send_record(8'sd5, 32'h0000_0003, 1'b0);
      send_record(-8'sd3, 32'h0000_0004, 1'b0);
      send_record(8'sd5, 32'h0000_0005, 1'b1);

      drain_pace = PACE_BURSTY;
      send_record(-8'sd100, 32'hAAAA_AAAA, 1'b0);
      send_record(-8'sd1, 32'h5555_5555, 1'b0);
      send_record(8'sd0, 32'h8000_0000, 1'b0);
      send_record(8'sd1, 32'h0000_0001, 1'b0);
      send_record(8'sd100, 32'h7FFF_FFFF, 1'b1);

      send_pace = PACE_BURSTY;
      send_record(8'h7F, 32'h1234_5678, 1'b0);
      send_record(8'sd64, 32'h9ABC_DEF0, 1'b0);
      send_record(8'sd0, 32'h0F0F_0F0F, 1'b0);
      send_record(-8'sd64, 32'hF0F0_F0F0, 1'b0);
      send_record(8'h80, 32'hDEAD_BEEF, 1'b1);
   endtask

   // Fills the store exactly, in reverse key order for the longest sort, then sends a
   // set two records too long so that its closing record arrives with the store full.
   task automatic test_capacity();
      logic signed [KEY_BITS-1:0] key;
      send_pace  = PACE_BURSTY;
      drain_pace = PACE_BURSTY;
      for (int i = 0; i < DEPTH; i++) begin
         key = KEY_BITS'(120 - 3 * i);
         send_record(key, $urandom, i == DEPTH - 1);
      end
      drain_pace = PACE_STEADY;
      for (int i = 0; i < DEPTH + 2; i++) begin
         key = KEY_BITS'($urandom);
         send_record(key, $urandom, i == DEPTH + 1);
      end
   endtask

   // Random sets, mostly small, some up to the full store and a few that overflow it.
   // Keys are scattered, clustered on a few values to exercise stability, or rising to
   // exercise the early exit. Both sides switch between steady and bursty pacing.
   task automatic test_random_sets();
      int                         set_size;
      int                         roll;
      int                         key_val;
      key_style_type              style;
      logic signed [KEY_BITS-1:0] key;
      while (records_sent < RANDOM_RECORDS) begin
         roll = $urandom_range(0, 99);
         if (roll < 80) begin
            set_size = $urandom_range(1, 8);
         end else if (roll < 95) begin
            set_size = $urandom_range(9, DEPTH);
         end else begin
            set_size = $urandom_range(DEPTH + 1, DEPTH + 3);
         end
         if ($urandom_range(0, 3) == 0) begin
            send_pace  = pace_type'($urandom_range(0, 1));
            drain_pace = pace_type'($urandom_range(0, 1));
         end
         style   = key_style_type'($urandom_range(0, 2));
         key_val = -128 + int'($urandom_range(0, 60));
         for (int i = 0; i < set_size; i++) begin
            case (style)
               KEYS_CLUSTERED: begin
                  key = KEY_BITS'(int'($urandom_range(0, 3)) - 1);
               end
               KEYS_RISING: begin
                  key_val = key_val + int'($urandom_range(0, 4));
                  if (key_val > 127) begin
                     key_val = 127;
                  end
                  key = KEY_BITS'(key_val);
               end
               default: begin
                  key = KEY_BITS'($urandom);
               end
            endcase
            send_record(key, $urandom, i == set_size - 1);
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_sets();
      test_capacity();
      test_random_sets();
      req_valid <= 1'b0;

      // Let the block finish the last run, then watch a while longer for extras.
      while (sorted_run_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d records in %0d sets, %0d of them over capacity.",
               records_sent, sets_closed, overflow_runs);
      $display("Checked %0d sorted records against the predicted runs.", records_checked);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> record_bubble_sort_by_first_byte.f
rtl/rbs_pkg.sv
rtl/rbs_ram.sv
rtl/record_bubble_sort_by_first_byte.sv
tb/record_bubble_sort_by_first_byte_tb.sv
